>>> rtl/core/brb_pkg.sv
// brb_pkg: sizes, status codes and slot entry types of the broadcast ring buffer
// used by the channel interfaces, the slot memory, the control and the top level
// no dependencies

package brb_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_READERS = 8;
    localparam int DATA_WIDTH  = 32;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PEND_W  = $clog2(MAX_READERS + 1);
    localparam int MARK_W  = MAX_READERS;
    localparam int RIDX_W  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int RID_W   = 3;
    localparam int CNT_W   = 4;
    localparam int STAT_W  = 2;
    localparam int WORD_W  = 32;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOTHING = 2'd2
    } t_status;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } t_req_type;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] word;
        logic [PEND_W-1:0]     pending;
        logic [MARK_W-1:0]     marks;
    } t_slot;

    typedef struct packed {
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        t_slot            wr_data;
    } t_mem_ctl;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

endpackage

>>> rtl/core/brb_req_if.sv
// brb_req_if: request channel (write a word or read by a reader)
// depends on brb_pkg

interface brb_req_if;
    import brb_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [RID_W-1:0]  reader_id;
    logic [WORD_W-1:0] wr_data;

    modport source (output valid, output req_type, output reader_id, output wr_data,
                    input ready);
    modport sink   (input valid, input req_type, input reader_id, input wr_data,
                    output ready);
endinterface

>>> rtl/core/brb_rsp_if.sv
// brb_rsp_if: response channel (status and read word)
// depends on brb_pkg

interface brb_rsp_if;
    import brb_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] rd_data;

    modport source (output valid, output status, output rd_data, input ready);
    modport sink   (input valid, input status, input rd_data, output ready);
endinterface

>>> rtl/core/brb_cfg_if.sv
// brb_cfg_if: configuration write channel for the reader count register
// depends on brb_pkg

interface brb_cfg_if;
    import brb_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] reader_count;

    modport source (output valid, output reader_count, input ready);
    modport sink   (input valid, input reader_count, output ready);
endinterface

>>> rtl/core/brb_slot_mem.sv
// brb_slot_mem: slot memory (word, pending count, read marks), one read and one write port
// registered read data, per-entry valid bits so pending and marks read as zero after reset
// depends on brb_pkg

module brb_slot_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brb_pkg::t_mem_ctl i_ctl,
    output brb_pkg::t_slot    o_rd_data
);
    import brb_pkg::*;

    t_slot            r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_slot            r_rd_entry;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_entry <= r_mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_ctl.rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_data = r_rd_entry;
        if (!r_rd_valid) begin
            o_rd_data.pending = '0;
            o_rd_data.marks   = '0;
        end
    end
endmodule

>>> rtl/core/brb_ctrl.sv
// brb_ctrl: request decode, write and reader pointers, slot read-modify-write, response register
// depends on brb_pkg, brb_req_if, brb_rsp_if

module brb_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [brb_pkg::CNT_W-1:0] i_reader_count,
    brb_req_if.sink                  i_req,
    brb_rsp_if.source                o_rsp,
    output brb_pkg::t_mem_ctl        o_mem_ctl,
    input  brb_pkg::t_slot           i_mem_rd
);
    import brb_pkg::*;

    logic                  r_busy;
    logic                  r_is_read;
    logic                  r_rid_ok;
    logic [RIDX_W-1:0]     r_ridx;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic [PTR_W-1:0]      r_addr;
    logic [PTR_W-1:0]      r_wp;
    logic [PTR_W-1:0]      r_rptr [MAX_READERS];
    logic                  r_out_valid;
    t_status               r_status;
    logic [WORD_W-1:0]     r_rd_data;

    logic                  accept;
    logic                  exec;
    logic [RIDX_W-1:0]     in_ridx;
    logic                  in_rid_ok;
    logic [PEND_W-1:0]     eff_count;
    logic [MARK_W-1:0]     rd_bit;
    logic                  adv_wp;
    logic                  adv_rp;
    t_status               n_status;
    logic [WORD_W-1:0]     n_rd_data;

    assign accept    = i_req.valid && i_req.ready;
    assign i_req.ready = !r_busy;
    assign exec      = r_busy && (!r_out_valid || o_rsp.ready);
    assign in_ridx   = RIDX_W'(i_req.reader_id);
    assign in_rid_ok = 32'(i_req.reader_id) < MAX_READERS;
    assign eff_count = (32'(i_reader_count) > MAX_READERS) ? PEND_W'(MAX_READERS)
                                                          : PEND_W'(i_reader_count);
    assign rd_bit    = MARK_W'(1) << r_ridx;

    always_comb begin
        o_mem_ctl.rd_en   = accept;
        o_mem_ctl.rd_addr = (i_req.req_type == REQ_WRITE) ? r_wp : r_rptr[in_ridx];
        o_mem_ctl.wr_en   = 1'b0;
        o_mem_ctl.wr_addr = r_addr;
        o_mem_ctl.wr_data = i_mem_rd;
        adv_wp    = 1'b0;
        adv_rp    = 1'b0;
        n_status  = ST_OK;
        n_rd_data = '0;
        if (!r_is_read) begin
            if (i_mem_rd.pending != '0) begin
                n_status = ST_FULL;
            end else begin
                o_mem_ctl.wr_en           = exec;
                o_mem_ctl.wr_data.word    = r_wdata;
                o_mem_ctl.wr_data.pending = eff_count;
                o_mem_ctl.wr_data.marks   = '0;
                adv_wp = 1'b1;
            end
        end else if (!r_rid_ok || i_mem_rd.pending == '0) begin
            n_status = ST_NOTHING;
        end else if ((i_mem_rd.marks & rd_bit) != '0) begin
            n_status = ST_NOTHING;
            adv_rp   = 1'b1;
        end else begin
            n_rd_data                 = WORD_W'(i_mem_rd.word);
            o_mem_ctl.wr_en           = exec;
            o_mem_ctl.wr_data.pending = i_mem_rd.pending - PEND_W'(1);
            o_mem_ctl.wr_data.marks   = i_mem_rd.marks | rd_bit;
            adv_rp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read <= (i_req.req_type == REQ_READ);
            r_rid_ok  <= in_rid_ok;
            r_ridx    <= in_ridx;
            r_wdata   <= DATA_WIDTH'(i_req.wr_data);
            r_addr    <= o_mem_ctl.rd_addr;
        end
        if (exec) begin
            r_status  <= n_status;
            r_rd_data <= n_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_wp        <= '0;
            for (int i = 0; i < MAX_READERS; i++) begin
                r_rptr[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (exec && adv_wp) begin
                r_wp <= next_slot(r_wp);
            end
            if (exec && adv_rp) begin
                r_rptr[r_ridx] <= next_slot(r_addr);
            end
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_status;
    assign o_rsp.rd_data = r_rd_data;

    a_out_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("response raised without a request in flight");

    a_wr_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.wr_en |-> exec)
        else $error("slot write outside the execute cycle");

    a_full_holds_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && n_status == ST_FULL) |=> $stable(r_wp))
        else $error("write pointer moved on a refused write");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.wr_en |-> 32'(o_mem_ctl.wr_data.pending) <= MAX_READERS)
        else $error("pending count above reader limit");
endmodule

>>> rtl/core/broadcast_ring_buffer.sv
// Broadcast ring buffer: one writer and up to eight readers share a ring of sixteen slots;
// each request (write, or read by a reader) gives one response with a status and a read word.
// The slot is read from the slot memory in the accept cycle, then modified and written back
// when the response register is free; a new request is taken only after that write-back.
// A full response register lets a new request be taken while a response waits. The user must
// write the reader count register via the configuration channel only while idle (unenforced).
// depends on brb_pkg, brb_req_if, brb_rsp_if, brb_cfg_if, brb_slot_mem, brb_ctrl

module broadcast_ring_buffer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brb_req_if.sink   i_req,
    brb_rsp_if.source o_rsp,
    brb_cfg_if.sink   i_cfg
);
    import brb_pkg::*;

    logic [CNT_W-1:0] r_reader_count;
    t_mem_ctl         mem_ctl;
    t_slot            mem_rd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reader_count <= CNT_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_reader_count <= i_cfg.reader_count;
        end
    end

    brb_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .o_rd_data (mem_rd)
    );

    brb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_reader_count (r_reader_count),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_mem_ctl      (mem_ctl),
        .i_mem_rd       (mem_rd)
    );
endmodule

>>> tb/ring_response_checker.sv
`timescale 1ns / 100ps
// ring_response_checker: watches the request, response and reader count channels of the
// broadcast ring buffer, predicts each response from its own copy of the ring, compares in order
// depends on brb_pkg, brb_req_if, brb_rsp_if, brb_cfg_if

module ring_response_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    brb_req_if   req,
    brb_rsp_if   rsp,
    brb_cfg_if   cfg,
    output int   o_outstanding,
    output int   o_fail_count
);
    import brb_pkg::*;

    typedef struct packed {
        t_status               status;
        logic [WORD_W-1:0]     rd_data;
    } t_outcome;

    logic [WORD_W-1:0] words [DEPTH];
    logic [PEND_W-1:0] pend [DEPTH];
    logic [MARK_W-1:0] marks [DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr [MAX_READERS];
    logic [CNT_W-1:0]  readers;
    t_outcome          awaited_responses[$];
    int                errors = 0;
    int                shown = 0;

    initial begin
        o_outstanding = 0;
        o_fail_count = 0;
    end

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic t_outcome serve_request(input t_req_type kind,
                                               input logic [RID_W-1:0] rid,
                                               input logic [WORD_W-1:0] word);
        t_outcome r;
        logic [PTR_W-1:0] p;
        r.status = ST_OK;
        r.rd_data = '0;
        if (kind == REQ_WRITE) begin
            if (pend[wr_ptr] != '0) begin
                r.status = ST_FULL;
            end else begin
                words[wr_ptr] = word;
                pend[wr_ptr] = (readers > CNT_W'(MAX_READERS)) ? PEND_W'(MAX_READERS)
                                                               : PEND_W'(readers);
                marks[wr_ptr] = '0;
                wr_ptr = advance(wr_ptr);
            end
        end else begin
            p = rd_ptr[rid];
            if (pend[p] == '0) begin
                r.status = ST_NOTHING;
            end else if (marks[p][rid]) begin
                r.status = ST_NOTHING;
                rd_ptr[rid] = advance(p);
            end else begin
                r.rd_data = words[p];
                pend[p] = pend[p] - PEND_W'(1);
                marks[p][rid] = 1'b1;
                rd_ptr[rid] = advance(p);
            end
        end
        return r;
    endfunction

    task automatic note_error(input string msg);
        if (shown < 10) begin
            $display("%0t: %s", $time, msg);
            shown++;
        end
        errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                pend[i] = '0;
                marks[i] = '0;
            end
            for (int i = 0; i < MAX_READERS; i++) rd_ptr[i] = '0;
            wr_ptr = '0;
            readers = CNT_W'(1);
            awaited_responses.delete();
            o_outstanding <= 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (awaited_responses.size() == 0) begin
                    note_error($sformatf("response with no request waiting: status %0d data %h",
                                         rsp.status, rsp.rd_data));
                end else begin
                    want = awaited_responses.pop_front();
                    if (rsp.status !== want.status)
                        note_error($sformatf("status: expected %0d, got %0d",
                                             want.status, rsp.status));
                    if (rsp.rd_data !== want.rd_data)
                        note_error($sformatf("rd_data: expected %h, got %h",
                                             want.rd_data, rsp.rd_data));
                end
            end
            if (cfg.valid && cfg.ready) readers = cfg.reader_count;
            if (req.valid && req.ready)
                awaited_responses.push_back(serve_request(t_req_type'(req.req_type),
                                                          req.reader_id, req.wr_data));
            o_outstanding <= awaited_responses.size();
            o_fail_count <= errors;
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench: drives requests and reader count writes into the broadcast ring buffer,
// stalls responses at random and gives the verdict from the response checker
// depends on brb_pkg, the channel interfaces, broadcast_ring_buffer, ring_response_checker

module testbench;
    import brb_pkg::*;

    localparam int PHASE_ITEMS = 60;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    int   outstanding;
    int   fail_count;
    bit   gaps_on = 1'b1;
    int   sent = 0;
    int   quiet_cycles = 0;
    logic [CNT_W-1:0] count_now = CNT_W'(1);
    logic [CNT_W-1:0] count_plan [6] = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd3, 4'd1};

    brb_req_if req_ch();
    brb_rsp_if rsp_ch();
    brb_cfg_if cfg_ch();

    broadcast_ring_buffer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    ring_response_checker ring_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg           (cfg_ch),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic issue(input t_req_type kind, input logic [RID_W-1:0] rid,
                         input logic [WORD_W-1:0] word);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.reader_id <= rid;
        req_ch.wr_data   <= word;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic write_word(input logic [WORD_W-1:0] word);
        issue(REQ_WRITE, RID_W'($urandom_range(0, MAX_READERS - 1)), word);
    endtask

    task automatic read_by(input logic [RID_W-1:0] rid);
        issue(REQ_READ, rid, $urandom);
    endtask

    // hold off new requests until every response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // response side: random stall per response, with calm stretches
    initial begin
        int stall;
        int calm_left;
        calm_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            if (calm_left > 0) begin
                stall = 0;
                calm_left--;
            end else begin
                stall = $urandom_range(0, 5);
                if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int stop;
        int pick;
        int k;
        int tmp;
        int swap_at;
        int n_active;
        logic [RID_W-1:0] rid;
        int order[$];

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_WRITE;
        req_ch.reader_id    <= '0;
        req_ch.wr_data      <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.reader_count <= CNT_W'(1);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, fill to the wrap, refused write, inactive reader served
        read_by(RID_W'(0));
        read_by(RID_W'(MAX_READERS - 1));
        write_word('0);
        write_word('1);
        repeat (DEPTH - 2) write_word($urandom);
        write_word(32'h1234_5678);
        read_by(RID_W'(MAX_READERS - 1));
        write_word(32'h5a5a_5a5a);
        read_by(RID_W'(0));
        read_by(RID_W'(0));

        foreach (count_plan[p]) begin
            drain_responses();
            cfg_ch.valid        <= 1'b1;
            cfg_ch.reader_count <= count_plan[p];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
            cfg_ch.valid <= 1'b0;
            count_now = count_plan[p];
            n_active = (count_now > MAX_READERS) ? MAX_READERS : count_now;
            stop = sent + PHASE_ITEMS;
            while (sent < stop) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 19);
                if (pick < 11) begin
                    // words written, then each active reader takes each once, interleaved
                    k = $urandom_range(1, 6);
                    repeat (k) write_word($urandom);
                    order.delete();
                    for (int r = 0; r < n_active; r++) repeat (k) order.push_back(r);
                    for (int i = order.size() - 1; i > 0; i--) begin
                        swap_at = $urandom_range(0, i);
                        tmp = order[i];
                        order[i] = order[swap_at];
                        order[swap_at] = tmp;
                    end
                    foreach (order[i]) read_by(RID_W'(order[i]));
                end else if (pick < 14) begin
                    repeat ($urandom_range(1, 6))
                        issue(t_req_type'($urandom_range(0, 1)),
                              RID_W'($urandom_range(0, MAX_READERS - 1)), $urandom);
                end else if (pick < 16) begin
                    repeat ($urandom_range(4, 18)) write_word($urandom);
                end else if (pick < 19) begin
                    // one reader runs ahead, possibly lapping the ring
                    rid = RID_W'($urandom_range(0, MAX_READERS - 1));
                    repeat ($urandom_range(1, 18)) read_by(rid);
                end else begin
                    drain_responses();
                end
            end
        end

        drain_responses();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/brb_pkg.sv
rtl/core/brb_req_if.sv
rtl/core/brb_rsp_if.sv
rtl/core/brb_cfg_if.sv
rtl/core/brb_slot_mem.sv
rtl/core/brb_ctrl.sv
rtl/core/broadcast_ring_buffer.sv
tb/ring_response_checker.sv
tb/testbench.sv
